>>> rtl/core/sle_pkg.sv
package sle_pkg;

    // One-hot decoder modes
    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_SQ   = 7'b0000010,
        MODE_DQ   = 7'b0000100,
        MODE_ESC  = 7'b0001000,
        MODE_OCT  = 7'b0010000,
        MODE_HEX  = 7'b0100000,
        MODE_UNI  = 7'b1000000
    } mode_t;

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_NOSTR  = 3'd2;
    localparam logic [2:0] ST_UNTERM = 3'd3;
    localparam logic [2:0] ST_BADHEX = 3'd4;
    localparam logic [2:0] ST_BADUNI = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    localparam logic [7:0] BYTE_BEL = 8'd7;
    localparam logic [7:0] BYTE_BS  = 8'd8;
    localparam logic [7:0] BYTE_FF  = 8'd12;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_CR  = 8'd13;
    localparam logic [7:0] BYTE_TAB = 8'd9;

    // Result queue depth: room for two results per beat plus two in flight
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  digit_count;
        logic [15:0] escape_value;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        mode:         MODE_IDLE,
        digit_count:  2'd0,
        escape_value: 16'd0
    };

    typedef struct packed {
        dec_state_t nxt;
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    function automatic result_t mk_byte(input logic [7:0] b);
        result_t r;
        r.has_byte = 1'b1;
        r.out_byte = b;
        r.status   = ST_RUN;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_status(input logic [2:0] s);
        result_t r;
        r.has_byte = 1'b0;
        r.out_byte = 8'd0;
        r.status   = s;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sle_if.sv
interface sle_in_if;
    import sle_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sle_out_if;
    import sle_pkg::*;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output has_byte, output out_byte, output status,
                    output last, input ready);
    modport sink   (input valid, input has_byte, input out_byte, input status,
                    input last, output ready);
endinterface

>>> rtl/core/string_literal_unescaper_unit.sv
// String literal unescaper.
// src carries one source byte per beat (in_byte, end_of_input); the first
// byte of a literal must be a quote. dst carries decoded results: a content
// byte (has_byte=1, status=0) or a final status (done, not a string,
// unterminated, bad hex, bad unicode). last marks the final result of a beat.
// A source beat yields zero, one or two results.
// Results are registered in the result queue before they reach dst.
// Throughput: one source beat per cycle while dst keeps up; a beat that
// yields two results hands them to dst one at a time. The four-entry result
// queue sets this: src.ready is high while at least two entries are free,
// so a new beat is taken while earlier results still wait on dst.
// When dst stalls, results hold in the queue and src.ready drops once
// fewer than two entries are free; nothing is lost.
// Reset clears the queue and returns the decoder to idle, waiting for an
// opening quote. Any final status also returns it to idle.
module string_literal_unescaper_unit
    import sle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sle_in_if.sink        src,
    sle_out_if.source     dst
);

    dec_state_t        state_reg;
    in_beat_t          beat;
    dec_out_t          dout;
    logic              accept;
    logic              pop;
    logic [1:0]        push_cnt;
    result_t           queue_reg [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg;
    logic [RES_AW-1:0] wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg;
    logic [RES_AW-1:0] rd_ptr_next;
    logic [RES_AW:0]   count_reg;
    logic [RES_AW:0]   count_next;
    result_t           head;

    assign beat.in_byte      = src.in_byte;
    assign beat.end_of_input = src.end_of_input;

    sle_decode u_decode (
        .cur  (state_reg),
        .beat (beat),
        .dout (dout)
    );

    assign src.ready = (count_reg <= (RES_AW + 1)'(RES_DEPTH - 2));
    assign accept    = src.valid && src.ready;
    assign push_cnt  = accept ? dout.cnt : 2'd0;
    assign pop       = dst.valid && dst.ready;

    assign head         = queue_reg[rd_ptr_reg];
    assign dst.valid    = (count_reg != '0);
    assign dst.has_byte = head.has_byte;
    assign dst.out_byte = head.out_byte;
    assign dst.status   = head.status;
    assign dst.last     = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_AW'(pop);
        count_next  = count_reg + (RES_AW + 1)'(push_cnt) - (RES_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= dout.nxt;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= dout.res0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + RES_AW'(1)] <= dout.res1;
        end
    end

`ifndef SYNTHESIS
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[RES_AW-1:0])
        else $error("result queue count out of step with pointers");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (RES_AW + 1)'(RES_DEPTH))
        else $error("result queue overflow");

    a_byte_running: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && dst.has_byte |-> dst.status == ST_RUN)
        else $error("decoded byte carries a final status");

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && dst.status != ST_RUN |-> dst.last && !dst.has_byte)
        else $error("final status not marked last");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((dout.cnt == 2'd1 && dout.res0.status != ST_RUN)
                || (dout.cnt == 2'd2 && dout.res1.status != ST_RUN))
        |=> state_reg.mode == MODE_IDLE)
        else $error("decoder not idle after a final status");
`endif

endmodule

>>> rtl/core/sle_decode.sv
module sle_decode
    import sle_pkg::*;
(
    input  dec_state_t cur,
    input  in_beat_t   beat,
    output dec_out_t   dout
);

    logic [7:0]  c;
    logic        eoi;
    logic [7:0]  l;
    logic [4:0]  hv;
    logic        is_oct;
    logic [7:0]  oct_val;
    logic [7:0]  hex_acc;
    logic [15:0] uni_acc;
    dec_state_t  nxt;
    logic [1:0]  cnt;
    result_t     r0;
    result_t     r1;

    always_comb
    begin
        c       = beat.in_byte;
        eoi     = beat.end_of_input;
        l       = to_lower(c);
        hv      = hex_val(c);
        is_oct  = (c[7:3] == 5'b00110);
        oct_val = {cur.escape_value[4:0], c[2:0]};
        hex_acc = {cur.escape_value[3:0], hv[3:0]};
        uni_acc = {cur.escape_value[11:0], hv[3:0]};
        nxt     = cur;
        cnt     = 2'd0;
        r0      = mk_status(ST_RUN);
        r1      = mk_status(ST_RUN);

        case (cur.mode)
            MODE_SQ:
            begin
                if (eoi || c == CH_NUL)
                begin
                    r0 = mk_status(ST_UNTERM); cnt = 2'd1; nxt = STATE_RESET;
                end
                else if (c == CH_SQUOTE)
                begin
                    r0 = mk_status(ST_DONE); cnt = 2'd1; nxt = STATE_RESET;
                end
                else
                begin
                    r0 = mk_byte(c); cnt = 2'd1;
                end
            end
            MODE_DQ:
            begin
                if (eoi || c == CH_NUL)
                begin
                    r0 = mk_status(ST_UNTERM); cnt = 2'd1; nxt = STATE_RESET;
                end
                else if (c == CH_DQUOTE)
                begin
                    r0 = mk_status(ST_DONE); cnt = 2'd1; nxt = STATE_RESET;
                end
                else if (c == CH_BSLASH)
                begin
                    nxt.mode = MODE_ESC;
                end
                else
                begin
                    r0 = mk_byte(c); cnt = 2'd1;
                end
            end
            MODE_ESC:
            begin
                nxt.mode = MODE_DQ;
                cnt      = 2'd1;
                if (eoi || c == CH_NUL)
                begin
                    r0 = mk_status(ST_UNTERM); nxt = STATE_RESET;
                end
                else if (l == CH_LOW_A) r0 = mk_byte(BYTE_BEL);
                else if (l == CH_LOW_B) r0 = mk_byte(BYTE_BS);
                else if (l == CH_LOW_F) r0 = mk_byte(BYTE_FF);
                else if (l == CH_LOW_N) r0 = mk_byte(BYTE_LF);
                else if (l == CH_LOW_R) r0 = mk_byte(BYTE_CR);
                else if (l == CH_LOW_T) r0 = mk_byte(BYTE_TAB);
                else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH)
                begin
                    r0 = mk_byte(c);
                end
                else if (l == CH_LOW_X || l == CH_LOW_U)
                begin
                    nxt.mode         = (l == CH_LOW_X) ? MODE_HEX : MODE_UNI;
                    nxt.digit_count  = 2'd0;
                    nxt.escape_value = 16'd0;
                    cnt              = 2'd0;
                end
                else if (is_oct)
                begin
                    nxt.mode         = MODE_OCT;
                    nxt.digit_count  = 2'd0;
                    nxt.escape_value = {13'd0, c[2:0]};
                    cnt              = 2'd0;
                end
                else
                begin
                    // unknown escape passes through with its backslash
                    r0  = mk_byte(CH_BSLASH);
                    r1  = mk_byte(c);
                    cnt = 2'd2;
                end
            end
            MODE_OCT:
            begin
                if (!eoi && is_oct)
                begin
                    if (cur.digit_count == 2'd2)
                    begin
                        r0       = mk_byte(oct_val);
                        cnt      = 2'd1;
                        nxt      = STATE_RESET;
                        nxt.mode = MODE_DQ;
                    end
                    else
                    begin
                        nxt.escape_value = {8'd0, oct_val};
                        nxt.digit_count  = cur.digit_count + 2'd1;
                    end
                end
                else
                begin
                    // flush the escape, then treat the ending byte as body text
                    r0       = mk_byte(cur.escape_value[7:0]);
                    cnt      = 2'd2;
                    nxt      = STATE_RESET;
                    nxt.mode = MODE_DQ;
                    if (eoi || c == CH_NUL)
                    begin
                        r1  = mk_status(ST_UNTERM);
                        nxt = STATE_RESET;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        r1  = mk_status(ST_DONE);
                        nxt = STATE_RESET;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        nxt.mode = MODE_ESC;
                        cnt      = 2'd1;
                    end
                    else
                    begin
                        r1 = mk_byte(c);
                    end
                end
            end
            MODE_HEX:
            begin
                if (eoi || hv[4])
                begin
                    r0 = mk_status(ST_BADHEX); cnt = 2'd1; nxt = STATE_RESET;
                end
                else if (cur.digit_count == 2'd1)
                begin
                    r0       = mk_byte(hex_acc);
                    cnt      = 2'd1;
                    nxt      = STATE_RESET;
                    nxt.mode = MODE_DQ;
                end
                else
                begin
                    nxt.escape_value = {8'd0, hex_acc};
                    nxt.digit_count  = 2'd1;
                end
            end
            MODE_UNI:
            begin
                if (eoi || hv[4])
                begin
                    r0 = mk_status(ST_BADUNI); cnt = 2'd1; nxt = STATE_RESET;
                end
                else if (cur.digit_count == 2'd3)
                begin
                    nxt      = STATE_RESET;
                    nxt.mode = MODE_DQ;
                    if (uni_acc[15:8] == 8'd0)
                    begin
                        r0  = mk_byte(uni_acc[7:0]);
                        cnt = 2'd1;
                    end
                    else
                    begin
                        r0  = mk_byte(uni_acc[15:8]);
                        r1  = mk_byte(uni_acc[7:0]);
                        cnt = 2'd2;
                    end
                end
                else
                begin
                    nxt.escape_value = uni_acc;
                    nxt.digit_count  = cur.digit_count + 2'd1;
                end
            end
            default:
            begin
                // idle: wait for an opening quote
                nxt = STATE_RESET;
                if (!eoi && c == CH_SQUOTE)
                begin
                    nxt.mode = MODE_SQ;
                end
                else if (!eoi && c == CH_DQUOTE)
                begin
                    nxt.mode = MODE_DQ;
                end
                else
                begin
                    r0  = mk_status(ST_NOSTR);
                    cnt = 2'd1;
                end
            end
        endcase

        if (cnt == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2)
        begin
            r1.last = 1'b1;
        end

        dout.nxt  = nxt;
        dout.cnt  = cnt;
        dout.res0 = r0;
        dout.res1 = r1;
    end

endmodule
